// ----- rtl/core/ile_pkg.sv -----
// Shared types and constants for the indexed list engine.
// Used by every file under rtl/core but ile_ram; depends on nothing.
`default_nettype none

package ile_pkg;

	// Storage size and the widths that follow from it.
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths of the channels.
	localparam int CMD_W  = 3;
	localparam int POS_W  = 7;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;

	// Width wide enough to compare a position against the entry count.
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Command codes carried on the request channel.
	typedef enum logic [CMD_W-1:0] {
		CMD_READ = 3'd0,
		CMD_HEAD = 3'd1,
		CMD_TAIL = 3'd2,
		CMD_AT   = 3'd3,
		CMD_DEL  = 3'd4
	} cmd_e;

	// Status codes carried on the response channel.
	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_e;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_LOOP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_RESP
	} state_e;

	// Read address select for the entry memory.
	typedef enum logic [1:0] {
		RD_TGT,
		RD_PREV,
		RD_NEXT
	} rd_sel_e;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    take;
		logic    check;
		logic    ram_re;
		rd_sel_e rd_sel;
		logic    ram_we;
		logic    wr_item;
		logic    idx_up;
		logic    idx_down;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    resp;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_valid;
		logic is_read;
		logic is_ins;
		logic is_del;
		logic err;
		logic more;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ile_if.sv -----
// Request and response channel interfaces of the indexed list engine.
// Depends on ile_pkg for the field widths.
`default_nettype none

// Request channel: one command per transfer.
interface ile_req_if;
	logic                             valid;
	logic                             ready;
	logic [ile_pkg::CMD_W-1:0]        command;
	logic [ile_pkg::POS_W-1:0]        position;
	logic signed [ile_pkg::DATA_W-1:0] item_value;

	modport source (output valid, command, position, item_value, input ready);
	modport sink (input valid, command, position, item_value, output ready);
endinterface

// Response channel: one result per command.
interface ile_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [ile_pkg::DATA_W-1:0] read_value;
	logic [ile_pkg::STAT_W-1:0]        status;
	logic [ile_pkg::LEN_W-1:0]         list_length;

	modport source (output valid, read_value, status, list_length, input ready);
	modport sink (input valid, read_value, status, list_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ile_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/ile_ctrl.sv -----
// Controller state machine of the indexed list engine.
// Depends on ile_pkg for the state, command and status types.
`default_nettype none

module ile_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ile_pkg::dp_stat_t stat,
	output ile_pkg::ctl_cmd_t      cmd
);

	ile_pkg::state_e state_q;
	ile_pkg::state_e state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ile_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = ile_pkg::RD_TGT;
		unique case (state_q)
			ile_pkg::S_IDLE: begin
				cmd.take = 1'b1;
				if (stat.req_valid) begin
					state_d = ile_pkg::S_CHECK;
				end
			end
			ile_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				priority if (stat.err) begin
					state_d = ile_pkg::S_RESP;
				end else if (stat.is_read) begin
					state_d = ile_pkg::S_READ;
				end else if (stat.is_ins || stat.is_del) begin
					state_d = ile_pkg::S_LOOP;
				end else begin
					state_d = ile_pkg::S_RESP;
				end
			end
			ile_pkg::S_READ: begin
				cmd.ram_re = 1'b1;
				cmd.rd_sel = ile_pkg::RD_TGT;
				state_d    = ile_pkg::S_RESP;
			end
			ile_pkg::S_LOOP: begin
				priority if (stat.more) begin
					state_d = ile_pkg::S_SHIFT_RD;
				end else if (stat.is_ins) begin
					state_d = ile_pkg::S_PUT;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = ile_pkg::S_RESP;
				end
			end
			ile_pkg::S_SHIFT_RD: begin
				cmd.ram_re = 1'b1;
				cmd.rd_sel = stat.is_ins ? ile_pkg::RD_PREV : ile_pkg::RD_NEXT;
				state_d    = ile_pkg::S_SHIFT_WR;
			end
			ile_pkg::S_SHIFT_WR: begin
				cmd.ram_we   = 1'b1;
				cmd.idx_down = stat.is_ins;
				cmd.idx_up   = !stat.is_ins;
				state_d      = ile_pkg::S_LOOP;
			end
			ile_pkg::S_PUT: begin
				cmd.ram_we  = 1'b1;
				cmd.wr_item = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = ile_pkg::S_RESP;
			end
			ile_pkg::S_RESP: begin
				if (stat.out_free) begin
					cmd.resp = 1'b1;
					state_d  = ile_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ile_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/ile_datapath.sv -----
// Datapath of the indexed list engine: command registers, entry count, shift
// index, entry memory and the response register.
// Depends on ile_pkg, ile_if and ile_ram.
`default_nettype none

module ile_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ile_req_if.sink                request,
	ile_rsp_if.source              response,
	input  wire ile_pkg::ctl_cmd_t cmd,
	output ile_pkg::dp_stat_t      stat
);

	logic [ile_pkg::CMD_W-1:0]   cmd_q;
	logic [ile_pkg::POS_W-1:0]   pos_q;
	logic [ile_pkg::DATA_W-1:0]  val_q;
	logic [ile_pkg::CNT_W-1:0]   count_q;
	logic [ile_pkg::ADDR_W-1:0]  idx_q;
	logic [ile_pkg::ADDR_W-1:0]  tgt_q;
	ile_pkg::status_e            status_q;
	ile_pkg::status_e            status_c;

	logic                        is_read;
	logic                        is_ins;
	logic                        is_del;
	logic [ile_pkg::CMP_W-1:0]   pos_ext;
	logic [ile_pkg::CMP_W-1:0]   cnt_ext;
	logic [ile_pkg::CMP_W-1:0]   eff_pos;
	logic                        more;

	logic                        ram_re;
	logic                        ram_we;
	logic [ile_pkg::ADDR_W-1:0]  ram_raddr;
	logic [ile_pkg::ADDR_W-1:0]  ram_waddr;
	logic [ile_pkg::DATA_W-1:0]  ram_wdata;
	logic [ile_pkg::DATA_W-1:0]  ram_rdata;

	logic                        out_valid_q;
	logic [ile_pkg::DATA_W-1:0]  out_value_q;
	logic [ile_pkg::STAT_W-1:0]  out_status_q;
	logic [ile_pkg::LEN_W-1:0]   out_length_q;
	logic                        load;

	// Request capture while the controller is idle.
	assign request.ready = cmd.take;
	assign load          = request.valid && cmd.take;

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= request.command;
			pos_q <= request.position;
			val_q <= request.item_value;
		end
	end

	// Command decode and range checks against the current count.
	assign is_read = (cmd_q == ile_pkg::CMD_READ);
	assign is_ins  = (cmd_q == ile_pkg::CMD_HEAD) || (cmd_q == ile_pkg::CMD_TAIL) ||
	                 (cmd_q == ile_pkg::CMD_AT);
	assign is_del  = (cmd_q == ile_pkg::CMD_DEL);
	assign pos_ext = ile_pkg::CMP_W'(pos_q);
	assign cnt_ext = ile_pkg::CMP_W'(count_q);

	always_comb begin
		unique case (cmd_q)
			ile_pkg::CMD_HEAD: eff_pos = '0;
			ile_pkg::CMD_TAIL: eff_pos = cnt_ext;
			default:           eff_pos = pos_ext;
		endcase
	end

	always_comb begin
		status_c = ile_pkg::ST_DONE;
		priority if ((is_read || is_del) && (pos_ext >= cnt_ext)) begin
			status_c = ile_pkg::ST_RANGE;
		end else if (is_ins && (eff_pos > cnt_ext)) begin
			status_c = ile_pkg::ST_RANGE;
		end else if (is_ins && (count_q >= ile_pkg::CNT_W'(ile_pkg::CAPACITY))) begin
			status_c = ile_pkg::ST_FULL;
		end else begin
			status_c = ile_pkg::ST_DONE;
		end
	end

	// Inserts move entries from the top down to the target; deletes move
	// entries from the target up to the end.
	always_comb begin
		if (is_ins) begin
			more = (idx_q > tgt_q);
		end else begin
			more = ((ile_pkg::CNT_W'(idx_q) + ile_pkg::CNT_W'(1)) < count_q);
		end
	end

	// Status, target and shift index.
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			status_q <= status_c;
			tgt_q    <= eff_pos[ile_pkg::ADDR_W-1:0];
			if (is_ins) begin
				idx_q <= count_q[ile_pkg::ADDR_W-1:0];
			end else begin
				idx_q <= pos_q[ile_pkg::ADDR_W-1:0];
			end
		end else if (cmd.idx_down) begin
			idx_q <= idx_q - ile_pkg::ADDR_W'(1);
		end else if (cmd.idx_up) begin
			idx_q <= idx_q + ile_pkg::ADDR_W'(1);
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + ile_pkg::CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - ile_pkg::CNT_W'(1);
		end
	end

	// Entry memory addressing.
	always_comb begin
		unique case (cmd.rd_sel)
			ile_pkg::RD_TGT:  ram_raddr = tgt_q;
			ile_pkg::RD_PREV: ram_raddr = idx_q - ile_pkg::ADDR_W'(1);
			ile_pkg::RD_NEXT: ram_raddr = idx_q + ile_pkg::ADDR_W'(1);
			default:          ram_raddr = tgt_q;
		endcase
	end

	assign ram_re    = cmd.ram_re;
	assign ram_we    = cmd.ram_we;
	assign ram_waddr = cmd.wr_item ? tgt_q : idx_q;
	assign ram_wdata = cmd.wr_item ? val_q : ram_rdata;

	ile_ram #(
		.WIDTH (ile_pkg::DATA_W),
		.DEPTH (ile_pkg::CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Response register; a new result loads only when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			if (is_read && (status_q == ile_pkg::ST_DONE)) begin
				out_value_q <= ram_rdata;
			end else begin
				out_value_q <= '1;
			end
			out_status_q <= status_q;
			out_length_q <= ile_pkg::LEN_W'(count_q);
		end
	end

	assign response.valid       = out_valid_q;
	assign response.read_value  = out_value_q;
	assign response.status      = out_status_q;
	assign response.list_length = out_length_q;

	// Status back to the controller.
	assign stat.req_valid = request.valid;
	assign stat.is_read   = is_read;
	assign stat.is_ins    = is_ins;
	assign stat.is_del    = is_del;
	assign stat.err       = (status_c != ile_pkg::ST_DONE);
	assign stat.more      = more;
	assign stat.out_free  = !out_valid_q || response.ready;

`ifndef SYNTHESIS
	// The count never passes the capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
		else $error("entry count above capacity");

	// A completed insert grows the list by exactly one entry.
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |=> count_q == $past(count_q) + ile_pkg::CNT_W'(1))
		else $error("insert did not grow the count by one");

	// A full status is only reported against a full list.
	a_full_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp && (status_q == ile_pkg::ST_FULL) |->
		count_q == ile_pkg::CNT_W'(ile_pkg::CAPACITY))
		else $error("full status with room left");

	// Writes stay within the list or one past its end.
	a_write_addr: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ile_pkg::CNT_W'(ram_waddr) <= count_q)
		else $error("entry write beyond the list end");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/indexed_list_engine.sv -----
// Top level of the indexed list engine: controller plus datapath.
// Depends on ile_pkg, ile_if, ile_ctrl, ile_datapath and ile_ram.
`default_nettype none

// The engine keeps an ordered list of up to CAPACITY (64) signed 32-bit values
// in a single-port-read, single-port-write memory and answers every request with
// exactly one response carrying the read value (-1 unless a valid read), a status
// (done, position out of range, list full) and the list length after the command.
// One command is worked at a time. A read checks the position and reads the memory;
// an error or an unused command goes from the check straight to the response; a
// delete or an insert shifts the entries from the target to the end, where each
// moved entry costs a memory read, a write and an index step, and an insert then
// writes the new item. A response that finds the previous one still waiting on the
// output holds until that one is taken. A new request is taken while the previous
// response still waits on the output. The memory needs no clearing after reset,
// since only entries below the current length are ever read.
module indexed_list_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	ile_req_if.sink   request,
	ile_rsp_if.source response
);

	ile_pkg::ctl_cmd_t ctl_cmd;
	ile_pkg::dp_stat_t dp_stat;

	// Sequencing.
	ile_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (dp_stat),
		.cmd    (ctl_cmd)
	);

	// Storage, checks and channel registers.
	ile_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response),
		.cmd      (ctl_cmd),
		.stat     (dp_stat)
	);

endmodule

`default_nettype wire

// ----- test/indexed_list_engine_tb.sv -----
// Self-checking testbench for indexed_list_engine: insert, delete and read traffic
// is checked against an in-bench list predictor under random idling on both channels.
// Depends on ile_pkg, ile_if and the engine RTL.
`default_nettype none

module indexed_list_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Command codes that the engine leaves unused.
	localparam logic [ile_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [ile_pkg::CMD_W-1:0] CMD_UNUSED_MID   = 3'd6;
	localparam logic [ile_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	// Wait after the last response, with margin over the longest insert.
	localparam int unsigned DRAIN_CYCLES    = 5 + 3 * ile_pkg::CAPACITY + 60;
	localparam int unsigned RUN_CYCLE_LIMIT = 1_000_000;

	// One response as the engine should present it.
	typedef struct packed {
		logic signed [ile_pkg::DATA_W-1:0] read_value;
		logic [ile_pkg::STAT_W-1:0]        status;
		logic [ile_pkg::LEN_W-1:0]         list_length;
	} list_result_t;

	logic clk;
	logic arst_n;

	ile_req_if request ();
	ile_rsp_if response ();

	indexed_list_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response)
	);

	// Predicted list contents and the responses still owed by the engine.
	logic signed [ile_pkg::DATA_W-1:0] shadow_list[$];
	list_result_t                      pending_results[$];

	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned fail_count   = 0;
	int unsigned cycle_count  = 0;
	bit          growing      = 1'b1;

	// Free-running clock with a 2 ns period.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// The response side stalls at random according to the current idle rate.
	always @(posedge clk) begin
		response.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Run limit: a hung engine ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Every response transfer is compared with the oldest outstanding prediction.
	always @(posedge clk) begin : check_responses
		list_result_t want;
		if (arst_n && response.valid && response.ready) begin
			if (pending_results.size() == 0) begin
				$error("response transfer with no command outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (response.read_value !== want.read_value) begin
					$error("read_value expected %0d got %0d", want.read_value,
						response.read_value);
					fail_count++;
				end
				if (response.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, response.status);
					fail_count++;
				end
				if (response.list_length !== want.list_length) begin
					$error("list_length expected %0d got %0d", want.list_length,
						response.list_length);
					fail_count++;
				end
			end
		end
	end

	// Inserts before pos, shifting later entries up; refuses past the end or when full.
	function automatic logic [ile_pkg::STAT_W-1:0] insert_entry(input int unsigned pos,
		input logic signed [ile_pkg::DATA_W-1:0] val);
		if (pos > shadow_list.size())
			return ile_pkg::ST_RANGE;
		if (shadow_list.size() >= ile_pkg::CAPACITY)
			return ile_pkg::ST_FULL;
		if (pos == shadow_list.size())
			shadow_list.push_back(val);
		else
			shadow_list.insert(pos, val);
		return ile_pkg::ST_DONE;
	endfunction

	// Applies one command to the predicted list and returns the response it owes.
	function automatic list_result_t apply_command(input logic [ile_pkg::CMD_W-1:0] cmd,
		input logic [ile_pkg::POS_W-1:0] pos,
		input logic signed [ile_pkg::DATA_W-1:0] val);
		list_result_t result;
		int unsigned  count;
		count              = shadow_list.size();
		result.read_value  = -1;
		result.status      = ile_pkg::ST_DONE;
		case (cmd)
			ile_pkg::CMD_READ: begin
				if (pos < count)
					result.read_value = shadow_list[pos];
				else
					result.status = ile_pkg::ST_RANGE;
			end
			ile_pkg::CMD_HEAD: result.status = insert_entry(0, val);
			ile_pkg::CMD_TAIL: result.status = insert_entry(count, val);
			ile_pkg::CMD_AT:   result.status = insert_entry(pos, val);
			ile_pkg::CMD_DEL: begin
				if (pos < count)
					shadow_list.delete(pos);
				else
					result.status = ile_pkg::ST_RANGE;
			end
			default: ;
		endcase
		result.list_length = ile_pkg::LEN_W'(shadow_list.size());
		return result;
	endfunction

	// Offers one command, waits for its transfer and records the predicted response.
	// Valid stays high after the transfer so back-to-back commands need no toggle.
	task automatic send_command(input logic [ile_pkg::CMD_W-1:0] cmd,
		input logic [ile_pkg::POS_W-1:0] pos,
		input logic signed [ile_pkg::DATA_W-1:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			request.valid <= 1'b0;
			@(posedge clk);
		end
		request.valid      <= 1'b1;
		request.command    <= cmd;
		request.position   <= pos;
		request.item_value <= val;
		@(posedge clk);
		while (!request.ready)
			@(posedge clk);
		pending_results.push_back(apply_command(cmd, pos, val));
	endtask

	// Random data word, with the sign extremes, zero and all-ones mixed in.
	function automatic logic signed [ile_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return {1'b0, {(ile_pkg::DATA_W-1){1'b1}}};
			1: return {1'b1, {(ile_pkg::DATA_W-1){1'b0}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly a position the command can use; now and then any 7-bit position.
	function automatic logic [ile_pkg::POS_W-1:0] pick_position(
		input logic [ile_pkg::CMD_W-1:0] cmd);
		int unsigned count;
		count = shadow_list.size();
		if ($urandom_range(99) < 12)
			return ile_pkg::POS_W'($urandom_range(127));
		if (cmd == ile_pkg::CMD_AT)
			return ile_pkg::POS_W'($urandom_range(count));
		if (count == 0)
			return '0;
		return ile_pkg::POS_W'($urandom_range(count - 1));
	endfunction

	// One of the three insert commands, chosen at random.
	function automatic logic [ile_pkg::CMD_W-1:0] pick_insert();
		case ($urandom_range(2))
			0: return ile_pkg::CMD_HEAD;
			1: return ile_pkg::CMD_TAIL;
			default: return ile_pkg::CMD_AT;
		endcase
	endfunction

	// Empty-list errors, every command, value extremes and out-of-range positions.
	task automatic test_directed_commands();
		send_command(ile_pkg::CMD_READ, 7'd0, '0);
		send_command(ile_pkg::CMD_DEL, 7'd0, '0);
		send_command(ile_pkg::CMD_AT, 7'd1, 32'sd5);
		send_command(ile_pkg::CMD_AT, 7'd127, 32'sd6);
		send_command(ile_pkg::CMD_HEAD, 7'd0, {1'b0, {(ile_pkg::DATA_W-1){1'b1}}});
		send_command(ile_pkg::CMD_TAIL, 7'd127, {1'b1, {(ile_pkg::DATA_W-1){1'b0}}});
		send_command(ile_pkg::CMD_AT, 7'd2, '1);
		send_command(ile_pkg::CMD_AT, 7'd1, '0);
		send_command(ile_pkg::CMD_HEAD, 7'd0, 32'sh5555_5555);
		for (int i = 0; i < 5; i++)
			send_command(ile_pkg::CMD_READ, i[ile_pkg::POS_W-1:0], '0);
		send_command(ile_pkg::CMD_READ, 7'd5, '0);
		send_command(ile_pkg::CMD_READ, 7'd127, '0);
		send_command(ile_pkg::CMD_DEL, 7'd127, '0);
		send_command(ile_pkg::CMD_DEL, 7'd4, '0);
		send_command(ile_pkg::CMD_DEL, 7'd0, '0);
		send_command(ile_pkg::CMD_DEL, 7'd1, '0);
		send_command(CMD_UNUSED_FIRST, 7'd127, '1);
		send_command(CMD_UNUSED_MID, 7'd0, 32'sd1);
		send_command(CMD_UNUSED_LAST, 7'd64, '1);
		send_command(ile_pkg::CMD_READ, 7'd0, '0);
	endtask

	// Fills the list to capacity, probes a full list, then empties it again.
	task automatic test_fill_and_drain();
		logic [ile_pkg::CMD_W-1:0] cmd;
		while (shadow_list.size() < ile_pkg::CAPACITY) begin
			cmd = pick_insert();
			send_command(cmd, ile_pkg::POS_W'($urandom_range(shadow_list.size())),
				pick_value());
		end
		send_command(ile_pkg::CMD_HEAD, '0, pick_value());
		send_command(ile_pkg::CMD_TAIL, '0, pick_value());
		send_command(ile_pkg::CMD_AT, ile_pkg::POS_W'($urandom_range(ile_pkg::CAPACITY)),
			pick_value());
		send_command(ile_pkg::CMD_AT,
			ile_pkg::POS_W'($urandom_range(127, ile_pkg::CAPACITY + 1)), pick_value());
		send_command(ile_pkg::CMD_READ, ile_pkg::POS_W'(ile_pkg::CAPACITY - 1), '0);
		send_command(ile_pkg::CMD_READ, ile_pkg::POS_W'(ile_pkg::CAPACITY), '0);
		send_command(ile_pkg::CMD_DEL, ile_pkg::POS_W'(ile_pkg::CAPACITY), '0);
		while (shadow_list.size() > 0) begin
			if ($urandom_range(3) == 0)
				send_command(ile_pkg::CMD_READ,
					ile_pkg::POS_W'($urandom_range(shadow_list.size() - 1)), '0);
			else
				send_command(ile_pkg::CMD_DEL,
					ile_pkg::POS_W'($urandom_range(shadow_list.size() - 1)), '0);
		end
		growing = 1'b1;
	endtask

	// Random traffic that swings between growing and shrinking the list.
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned               roll;
		int unsigned               insert_limit;
		logic [ile_pkg::CMD_W-1:0] cmd;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (shadow_list.size() == 0)
				growing = 1'b1;
			else if (shadow_list.size() == ile_pkg::CAPACITY && $urandom_range(3) == 0)
				growing = 1'b0;
			else if ($urandom_range(99) == 0)
				growing = !growing;
			insert_limit = growing ? 85 : 40;
			roll         = $urandom_range(99);
			if (roll < 4)
				cmd = ile_pkg::CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
			else if (roll < 20)
				cmd = ile_pkg::CMD_READ;
			else if (roll < insert_limit)
				cmd = pick_insert();
			else
				cmd = ile_pkg::CMD_DEL;
			send_command(cmd, pick_position(cmd), pick_value());
		end
	endtask

	// Test sequence: reset, then the tests under each idling profile.
	initial begin
		arst_n              = 1'b0;
		request.valid       = 1'b0;
		request.command     = ile_pkg::CMD_READ;
		request.position    = '0;
		request.item_value  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 30;
		snk_idle_pct = 64;
		test_directed_commands();
		test_fill_and_drain();
		test_random_traffic(120);

		src_idle_pct = 64;
		snk_idle_pct = 30;
		test_random_traffic(120);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_fill_and_drain();
		test_random_traffic(80);

		// Drop valid after the last transfer, then let every response come back.
		request.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

// ----- indexed_list_engine.f -----
rtl/core/ile_pkg.sv
rtl/core/ile_if.sv
rtl/core/ile_ram.sv
rtl/core/ile_ctrl.sv
rtl/core/ile_datapath.sv
rtl/core/indexed_list_engine.sv
test/indexed_list_engine_tb.sv
